>>> rtl/grid_line_cell_walker_assert.svh
// Assertion macros for the grid line walker controller.
`ifndef GRID_LINE_CELL_WALKER_ASSERT_SVH
`define GRID_LINE_CELL_WALKER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define GLCW_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define GLCW_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/glcw_pkg.sv
// Shared constants and control types of the grid line walker.
package glcw_pkg;

	localparam int GRID_SIZE = 64;
	localparam int COORD_W   = 6;
	localparam int GRID_W    = 7;
	localparam int ERR_W     = 9;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = GRID_W;

	localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(GRID_SIZE - 1);
	localparam logic [GRID_W-1:0]  GRID_MAX  = GRID_W'(GRID_SIZE);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'b1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic step;
	} glcw_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic zero_len;
		logic last;
	} glcw_sts_t;

endpackage

>>> rtl/glcw_seg_if.sv
// Stream channels: segment items in, visited cell items out.
interface glcw_seg_if import glcw_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] start_col;
	logic [COORD_W-1:0] start_row;
	logic [COORD_W-1:0] end_col;
	logic [COORD_W-1:0] end_row;

	modport source (output valid, start_col, start_row, end_col, end_row, input ready);
	modport sink (input valid, start_col, start_row, end_col, end_row, output ready);
endinterface

interface glcw_visit_if import glcw_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] cell_row;
	logic [COORD_W-1:0] cell_col;
	logic               last;

	modport source (output valid, cell_row, cell_col, last, input ready);
	modport sink (input valid, cell_row, cell_col, last, output ready);
endinterface

>>> rtl/glcw_datapath.sv
// Datapath: config registers, line setup and one Bresenham step per cycle while cells are taken.
module glcw_datapath import glcw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  glcw_cmd_t             cmd,
	output glcw_sts_t             sts,
	input  logic [COORD_W-1:0]    start_col,
	input  logic [COORD_W-1:0]    start_row,
	input  logic [COORD_W-1:0]    end_col,
	input  logic [COORD_W-1:0]    end_row,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic [COORD_W-1:0]    cell_row,
	output logic [COORD_W-1:0]    cell_col
);

	function automatic logic [COORD_W-1:0] sat_coord(input logic [COORD_W-1:0] v);
		return (v > COORD_MAX) ? COORD_MAX : v;
	endfunction

	function automatic logic [COORD_W-1:0] grid_limit(input logic [GRID_W-1:0] g);
		logic [GRID_W-1:0] m;
		m = g - GRID_W'(1);
		if (g == '0)
			return '0;
		else if (g > GRID_MAX)
			return COORD_MAX;
		else
			return m[COORD_W-1:0];
	endfunction

	logic [GRID_W-1:0]  grid_rows_q, grid_cols_q;
	logic [COORD_W-1:0] x_q, y_q, x1_q, y1_q, dx_q, dy_q, row_hi_q, col_hi_q;
	logic               sx_q, sy_q;
	logic signed [ERR_W-1:0] err_q;

	logic [COORD_W-1:0] x0_in, y0_in, x1_in, y1_in, dx_in, dy_in;
	logic signed [ERR_W-1:0] err_in, err_nxt;
	logic signed [ERR_W:0]   e2, neg_dy, pos_dx;
	logic               step_x, step_y;
	logic [COORD_W-1:0] x_nxt, y_nxt;

	// Hold the grid size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= GRID_MAX;
			grid_cols_q <= GRID_MAX;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_GRID_ROWS: grid_rows_q <= cfg_data;
				CFG_GRID_COLS: grid_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Set up the segment from the incoming item
	always_comb begin
		x0_in  = sat_coord(start_col);
		y0_in  = sat_coord(start_row);
		x1_in  = sat_coord(end_col);
		y1_in  = sat_coord(end_row);
		dx_in  = (x1_in > x0_in) ? (x1_in - x0_in) : (x0_in - x1_in);
		dy_in  = (y1_in > y0_in) ? (y1_in - y0_in) : (y0_in - y1_in);
		err_in = $signed(ERR_W'(dx_in)) - $signed(ERR_W'(dy_in));
	end

	// Compute the next cell of the walk
	always_comb begin
		e2      = $signed({err_q, 1'b0});
		neg_dy  = -$signed((ERR_W+1)'(dy_q));
		pos_dx  = $signed((ERR_W+1)'(dx_q));
		step_x  = (e2 > neg_dy);
		step_y  = (e2 < pos_dx);
		err_nxt = err_q;
		x_nxt   = x_q;
		y_nxt   = y_q;
		if (step_x) begin
			err_nxt = err_nxt - $signed(ERR_W'(dy_q));
			x_nxt   = sx_q ? (x_q + COORD_W'(1)) : (x_q - COORD_W'(1));
		end
		if (step_y) begin
			err_nxt = err_nxt + $signed(ERR_W'(dx_q));
			y_nxt   = sy_q ? (y_q + COORD_W'(1)) : (y_q - COORD_W'(1));
		end
	end

	// Load on accept, advance on each delivered cell
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q      <= x0_in;
			y_q      <= y0_in;
			x1_q     <= x1_in;
			y1_q     <= y1_in;
			dx_q     <= dx_in;
			dy_q     <= dy_in;
			sx_q     <= (x0_in < x1_in);
			sy_q     <= (y0_in < y1_in);
			err_q    <= err_in;
			row_hi_q <= grid_limit(grid_rows_q);
			col_hi_q <= grid_limit(grid_cols_q);
		end else if (cmd.step) begin
			x_q   <= x_nxt;
			y_q   <= y_nxt;
			err_q <= err_nxt;
		end
	end

	assign sts.zero_len = (x0_in == x1_in) && (y0_in == y1_in);
	assign sts.last     = (x_nxt == x1_q) && (y_nxt == y1_q);

	// Clamp the current cell to the grid
	assign cell_row = (y_q > row_hi_q) ? row_hi_q : y_q;
	assign cell_col = (x_q > col_hi_q) ? col_hi_q : x_q;

endmodule

>>> rtl/glcw_ctrl.sv
// Controller: accepts one segment item at a time and paces the walk.
`include "grid_line_cell_walker_assert.svh"
module glcw_ctrl import glcw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output glcw_cmd_t cmd,
	input  glcw_sts_t sts
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_WALK = 1'b1;

	logic state_q, state_nxt;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_WALK);
	assign cmd.load  = in_valid && in_ready;
	assign cmd.step  = out_valid && out_ready;

	// Move between waiting for a segment and walking it
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.load && !sts.zero_len)
					state_nxt = ST_WALK;
			end
			ST_WALK: begin
				if (cmd.step && sts.last)
					state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	`GLCW_ASSERT(a_no_load_while_walking, out_valid |-> !cmd.load, "segment accepted during walk")
	`GLCW_ASSERT(a_last_ends_walk, (cmd.step && sts.last) |=> in_ready, "walk did not end on last cell")
	`GLCW_ASSERT(a_zero_len_no_cells, (cmd.load && sts.zero_len) |=> !out_valid, "empty segment gave a cell")
	`GLCW_ASSERT(a_walk_continues, (cmd.step && !sts.last) |=> out_valid, "walk stopped before last cell")

endmodule

>>> rtl/grid_line_cell_walker.sv
// Top level of the grid line walker: Bresenham cells of a segment, clamped to the grid.
//
//   channel   direction  contents
//   segment   in         start_col, start_row, end_col, end_row
//   visit     out        cell_row, cell_col, last
//   cfg       in         cfg_we, cfg_idx, cfg_data (grid_rows, grid_cols)
//
// A segment of Chebyshev length n gives n cells, one per cycle while visit
// is not stalled; the next segment is accepted only after its last cell.
// The single walk register set in the datapath allows one segment at a time.
// A stall on visit holds the current cell; a zero-length segment gives no cells.
// Reset returns the controller to idle and both grid sizes to 64.
module grid_line_cell_walker import glcw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	glcw_seg_if.sink              segment,
	glcw_visit_if.source          visit,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	glcw_cmd_t cmd;
	glcw_sts_t sts;

	glcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (segment.valid),
		.in_ready  (segment.ready),
		.out_valid (visit.valid),
		.out_ready (visit.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	glcw_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.start_col (segment.start_col),
		.start_row (segment.start_row),
		.end_col   (segment.end_col),
		.end_row   (segment.end_row),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.cell_row  (visit.cell_row),
		.cell_col  (visit.cell_col)
	);

	// Flag the final cell of the segment
	assign visit.last = sts.last;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Testbench of the grid line walker: segments in, visited cells checked against a line predictor.
module tb;
	import glcw_pkg::*;

	localparam int unsigned LIMIT_CYCLES = 6_000_000;
	localparam int          HOLD_CYCLES  = 400;
	localparam int          SETTLE       = 8;
	localparam int          PHASES       = 10;
	localparam int          PHASE_ITEMS  = 50;
	localparam int          MAX_PRINTS   = 40;

	// How a directed row gets its expected visits
	localparam int PIN_MODEL = -1;
	localparam int PIN_NONE  = 0;
	localparam int PIN_ONE   = 1;

	typedef struct packed {
		logic [COORD_W-1:0] start_col;
		logic [COORD_W-1:0] start_row;
		logic [COORD_W-1:0] end_col;
		logic [COORD_W-1:0] end_row;
	} seg_t;

	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic               last;
	} visit_t;

	// Grid sizes, segment, and for pinned rows the single visit typed in by hand
	typedef struct {
		int rows;
		int cols;
		int sc;
		int sr;
		int ec;
		int er;
		int pin;
		int pin_row;
		int pin_col;
	} plan_row_t;

	plan_row_t plan [22] = '{
		'{ 64,  64,  5,  9,  5,  9, PIN_NONE,   0,  0},
		'{ 64,  64,  0,  0,  0,  0, PIN_NONE,   0,  0},
		'{ 64,  64, 63, 63, 63, 63, PIN_NONE,   0,  0},
		'{ 64,  64,  0,  0,  1,  0, PIN_ONE,    0,  0},
		'{ 64,  64, 63, 63, 62, 62, PIN_ONE,   63, 63},
		'{ 64,  64, 63,  0, 62,  1, PIN_ONE,    0, 63},
		'{ 64,  64,  0,  0, 63,  0, PIN_MODEL,  0,  0},
		'{ 64,  64,  0,  0,  0, 63, PIN_MODEL,  0,  0},
		'{ 64,  64,  0,  0, 63, 63, PIN_MODEL,  0,  0},
		'{ 64,  64, 63, 63,  0,  0, PIN_MODEL,  0,  0},
		'{ 64,  64,  0, 63, 63,  0, PIN_MODEL,  0,  0},
		'{ 64,  64,  2,  1, 60, 17, PIN_MODEL,  0,  0},
		'{ 64,  64, 40,  2, 31, 61, PIN_MODEL,  0,  0},
		'{ 64,  64, 42, 21, 21, 42, PIN_MODEL,  0,  0},
		'{  0,   0, 63, 63, 62, 62, PIN_ONE,    0,  0},
		'{  0,   0, 10, 20, 50, 30, PIN_MODEL,  0,  0},
		'{  1,   1,  0,  0, 63, 63, PIN_MODEL,  0,  0},
		'{127, 127, 63,  0,  0, 63, PIN_MODEL,  0,  0},
		'{127, 127, 63, 63, 62, 62, PIN_ONE,   63, 63},
		'{ 32,  16,  0,  0, 63, 63, PIN_MODEL,  0,  0},
		'{ 32,  16, 63, 10, 62, 10, PIN_ONE,   10, 15},
		'{ 64,  64,  1,  0,  0,  0, PIN_ONE,    0,  1}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	glcw_seg_if   segment_ch ();
	glcw_visit_if visit_ch ();

	grid_line_cell_walker uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.segment  (segment_ch),
		.visit    (visit_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// Shadow of the grid registers and the visits still owed by the block
	logic [GRID_W-1:0] rows_m;
	logic [GRID_W-1:0] cols_m;
	visit_t            visit_q [$];

	int unsigned cycles     = 0;
	int unsigned mismatches = 0;
	bit          idle_on    = 1'b1;
	int          hold_req   = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	// Give up on a hung block
	initial begin
		wait (cycles >= LIMIT_CYCLES);
		$display("timeout at cycle %0d with %0d visits outstanding", cycles, visit_q.size());
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (!idle_on) begin
			return 0;
		end
		r = $urandom_range(0, 15);
		if (r < 8) begin
			return 0;
		end
		if (r < 14) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// Highest index on one axis for a grid size register
	function automatic int grid_hi(input logic [GRID_W-1:0] g);
		if (g == 0) begin
			return 0;
		end
		if (g > GRID_SIZE) begin
			return GRID_SIZE - 1;
		end
		return int'(g) - 1;
	endfunction

	function automatic logic [COORD_W-1:0] clamp_axis(input int v, input int hi);
		if (v < 0) begin
			return '0;
		end
		return COORD_W'((v > hi) ? hi : v);
	endfunction

	// Append one visit to the owed list
	function automatic void owe_visit(input visit_t v);
		visit_q.insert(visit_q.size(), v);
	endfunction

	// Walk the Bresenham line and queue every visit short of the end point
	function automatic void walk_segment(input seg_t s);
		int     x;
		int     y;
		int     x1;
		int     y1;
		int     dx;
		int     dy;
		int     sx;
		int     sy;
		int     err;
		int     e2;
		int     row_hi;
		int     col_hi;
		int     n;
		visit_t v;
		x      = int'(s.start_col);
		y      = int'(s.start_row);
		x1     = int'(s.end_col);
		y1     = int'(s.end_row);
		row_hi = grid_hi(rows_m);
		col_hi = grid_hi(cols_m);
		dx     = (x1 > x) ? x1 - x : x - x1;
		dy     = (y1 > y) ? y1 - y : y - y1;
		sx     = (x < x1) ? 1 : -1;
		sy     = (y < y1) ? 1 : -1;
		err    = dx - dy;
		n      = 0;
		while ((x != x1 || y != y1) && n < GRID_SIZE - 1) begin
			e2    = 2 * err;
			v.row = clamp_axis(y, row_hi);
			v.col = clamp_axis(x, col_hi);
			if (e2 > -dy) begin
				err -= dy;
				x   += sx;
			end
			if (e2 < dx) begin
				err += dx;
				y   += sy;
			end
			n++;
			v.last = (x == x1 && y == y1) || n == GRID_SIZE - 1;
			owe_visit(v);
		end
	endfunction

	task automatic flag_mismatch(input string msg);
		if (mismatches < MAX_PRINTS) begin
			$display("[cycle %0d] mismatch: %s", cycles, msg);
		end
		mismatches++;
	endtask

	// Compare each accepted visit with the oldest one owed
	always @(posedge clk) begin : visit_check
		visit_t want;
		if (arst_n && visit_ch.valid && visit_ch.ready) begin
			if (visit_q.size() == 0) begin
				flag_mismatch($sformatf("visit row %0d col %0d last %0b with none owed",
					visit_ch.cell_row, visit_ch.cell_col, visit_ch.last));
			end else begin
				want = visit_q.pop_front();
				if (visit_ch.cell_row !== want.row) begin
					flag_mismatch($sformatf("cell_row %0d, expected %0d", visit_ch.cell_row, want.row));
				end
				if (visit_ch.cell_col !== want.col) begin
					flag_mismatch($sformatf("cell_col %0d, expected %0d", visit_ch.cell_col, want.col));
				end
				if (visit_ch.last !== want.last) begin
					flag_mismatch($sformatf("last %0b, expected %0b", visit_ch.last, want.last));
				end
			end
		end
	end

	// Drive ready: random stalls, plus a long hold-off on request
	initial begin : visit_sink
		int stall_left;
		int hold_seen;
		stall_left = 0;
		hold_seen  = 0;
		visit_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen  = hold_req;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				visit_ch.ready <= 1'b0;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				visit_ch.ready <= 1'b0;
				stall_left = pick_gap();
			end else begin
				visit_ch.ready <= 1'b1;
			end
		end
	end

	// Offer one segment item after a random gap; predict its visits once accepted
	task automatic send_segment(input seg_t s, input bit predict);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			segment_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		segment_ch.valid     <= 1'b1;
		segment_ch.start_col <= s.start_col;
		segment_ch.start_row <= s.start_row;
		segment_ch.end_col   <= s.end_col;
		segment_ch.end_row   <= s.end_row;
		do @(posedge clk); while (!segment_ch.ready);
		if (predict) begin
			walk_segment(s);
		end
	endtask

	// Hold off the sender until every owed visit has come, then let the block settle
	task automatic wait_drained();
		segment_ch.valid <= 1'b0;
		while (visit_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_grid(input logic [GRID_W-1:0] rows, input logic [GRID_W-1:0] cols);
		cfg_we   <= 1'b1;
		cfg_idx  <= CFG_GRID_ROWS;
		cfg_data <= rows;
		@(posedge clk);
		cfg_idx  <= CFG_GRID_COLS;
		cfg_data <= cols;
		@(posedge clk);
		cfg_we   <= 1'b0;
		rows_m = rows;
		cols_m = cols;
	endtask

	function automatic logic [GRID_W-1:0] pick_grid();
		case ($urandom_range(0, 7))
			0: begin
				return '0;
			end
			1: begin
				return GRID_W'(1);
			end
			2: begin
				return GRID_MAX;
			end
			3: begin
				return '1;
			end
			4: begin
				return GRID_W'($urandom_range(GRID_SIZE + 1, 127));
			end
			default: begin
				return GRID_W'($urandom_range(1, GRID_SIZE));
			end
		endcase
	endfunction

	function automatic logic [COORD_W-1:0] near(input logic [COORD_W-1:0] v);
		int t;
		t = int'(v) + $urandom_range(0, 6) - 3;
		if (t < 0) begin
			t = 0;
		end
		if (t > GRID_SIZE - 1) begin
			t = GRID_SIZE - 1;
		end
		return COORD_W'(t);
	endfunction

	// Random segment: uniform, short, axis-aligned, diagonal, on the border, or zero length
	function automatic seg_t pick_segment();
		seg_t s;
		int   d;
		s = seg_t'(24'($urandom));
		case ($urandom_range(0, 9))
			3, 4: begin
				s.end_col = near(s.start_col);
				s.end_row = near(s.start_row);
			end
			5: begin
				s.end_row = s.start_row;
			end
			6: begin
				s.end_col = s.start_col;
			end
			7: begin
				d = int'((s.end_col > s.start_col) ? s.end_col - s.start_col
					: s.start_col - s.end_col);
				if (int'(s.start_row) + d <= GRID_SIZE - 1) begin
					s.end_row = COORD_W'(int'(s.start_row) + d);
				end else begin
					s.end_row = COORD_W'(int'(s.start_row) - d);
				end
			end
			8: begin
				if ($urandom_range(0, 1)) s.start_col = $urandom_range(0, 1) ? COORD_MAX : '0;
				if ($urandom_range(0, 1)) s.start_row = $urandom_range(0, 1) ? COORD_MAX : '0;
				if ($urandom_range(0, 1)) s.end_col = $urandom_range(0, 1) ? COORD_MAX : '0;
				if ($urandom_range(0, 1)) s.end_row = $urandom_range(0, 1) ? COORD_MAX : '0;
			end
			9: begin
				s.end_col = s.start_col;
				s.end_row = s.start_row;
			end
			default: begin
			end
		endcase
		return s;
	endfunction

	initial begin : stimulus
		seg_t   s;
		visit_t v;
		arst_n               <= 1'b0;
		cfg_we               <= 1'b0;
		cfg_idx              <= CFG_GRID_ROWS;
		cfg_data             <= '0;
		segment_ch.valid     <= 1'b0;
		segment_ch.start_col <= '0;
		segment_ch.start_row <= '0;
		segment_ch.end_col   <= '0;
		segment_ch.end_row   <= '0;
		rows_m = GRID_MAX;
		cols_m = GRID_MAX;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows: extremes, clamping, zero and one-step segments
		foreach (plan[k]) begin
			if (plan[k].rows != rows_m || plan[k].cols != cols_m) begin
				wait_drained();
				write_grid(GRID_W'(plan[k].rows), GRID_W'(plan[k].cols));
			end
			s.start_col = COORD_W'(plan[k].sc);
			s.start_row = COORD_W'(plan[k].sr);
			s.end_col   = COORD_W'(plan[k].ec);
			s.end_row   = COORD_W'(plan[k].er);
			if (plan[k].pin == PIN_ONE) begin
				v.row  = COORD_W'(plan[k].pin_row);
				v.col  = COORD_W'(plan[k].pin_col);
				v.last = 1'b1;
				owe_visit(v);
			end
			send_segment(s, plan[k].pin == PIN_MODEL);
		end

		// Random phases, each under its own grid sizes; the first holds off the receiver
		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			idle_on = (p % 4 != 2);
			if (p == 0) begin
				write_grid(GRID_MAX, GRID_MAX);
				hold_req++;
			end else begin
				write_grid(pick_grid(), pick_grid());
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				send_segment(pick_segment(), 1'b1);
			end
		end

		wait_drained();
		if (mismatches == 0 && visit_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

>>> grid_line_cell_walker.f
+incdir+rtl
rtl/glcw_pkg.sv
rtl/glcw_seg_if.sv
rtl/glcw_datapath.sv
rtl/glcw_ctrl.sv
rtl/grid_line_cell_walker.sv
tb/tb.sv
